### rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int REC_W        = 32;
    localparam int PRI_W        = 8;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_INSERT,
        OP_REMOVE
    } t_op;

    typedef struct packed {
        logic                load;
        logic                exec;
        t_op                 op;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/spq_if.sv
`default_nettype none

interface spq_req_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [spq_pkg::REC_W-1:0]   record;
    logic [spq_pkg::PRI_W-1:0]   priority_req;

    modport source (output valid, output cmd, output record, output priority_req,
                    input ready);
    modport sink   (input valid, input cmd, input record, input priority_req,
                    output ready);
endinterface

interface spq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [spq_pkg::REC_W-1:0]    head_record;
    logic [spq_pkg::PRI_W-1:0]    head_priority;
    logic                         head_valid;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output head_record, output head_priority,
                    output head_valid, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input head_record, input head_priority,
                    input head_valid, input status, input occupancy,
                    output ready);
endinterface

`default_nettype wire

### rtl/spq_datapath.sv
`default_nettype none

module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire spq_pkg::t_dp_cmd             i_cmd,
    output spq_pkg::t_dp_stat                 o_stat,
    input  wire logic [spq_pkg::REC_W-1:0]    i_record,
    input  wire logic [spq_pkg::PRI_W-1:0]    i_priority,
    output logic      [spq_pkg::REC_W-1:0]    o_head_record,
    output logic      [spq_pkg::PRI_W-1:0]    o_head_priority,
    output logic                              o_head_valid,
    output logic      [spq_pkg::STATUS_W-1:0] o_status,
    output logic      [spq_pkg::OCC_W-1:0]    o_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [spq_pkg::REC_W-1:0]    r_rec [CAPACITY];
    logic [spq_pkg::PRI_W-1:0]    r_pri [CAPACITY];
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic [spq_pkg::REC_W-1:0]    r_in_rec;
    logic [spq_pkg::PRI_W-1:0]    r_in_pri;
    logic [spq_pkg::REC_W-1:0]    r_head_rec;
    logic [spq_pkg::PRI_W-1:0]    r_head_pri;
    logic                         r_head_valid;
    logic [spq_pkg::STATUS_W-1:0] r_status;
    logic [CAPACITY-1:0]          w_keep;

    // slot stays put on insert: held and at least as high as the new entry
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_keep[i] = (CNT_W'(i) < r_count) && (r_pri[i] >= r_in_pri);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                      w_prev_keep;
        logic [spq_pkg::REC_W-1:0] w_up_rec;
        logic [spq_pkg::PRI_W-1:0] w_up_pri;
        logic [spq_pkg::REC_W-1:0] w_dn_rec;
        logic [spq_pkg::PRI_W-1:0] w_dn_pri;

        if (g == 0) begin : g_first
            assign w_prev_keep = 1'b1;
            assign w_up_rec    = r_in_rec;
            assign w_up_pri    = r_in_pri;
        end else begin : g_rest
            assign w_prev_keep = w_keep[g-1];
            assign w_up_rec    = r_rec[g-1];
            assign w_up_pri    = r_pri[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_dn_rec = r_rec[g];
            assign w_dn_pri = r_pri[g];
        end else begin : g_inner
            assign w_dn_rec = r_rec[g+1];
            assign w_dn_pri = r_pri[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) begin
                case (i_cmd.op)
                    spq_pkg::OP_INSERT: begin
                        if (!w_keep[g]) begin
                            if (w_prev_keep) begin
                                r_rec[g] <= r_in_rec;
                                r_pri[g] <= r_in_pri;
                            end else begin
                                r_rec[g] <= w_up_rec;
                                r_pri[g] <= w_up_pri;
                            end
                        end
                    end
                    spq_pkg::OP_REMOVE: begin
                        r_rec[g] <= w_dn_rec;
                        r_pri[g] <= w_dn_pri;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_count = r_count;
        case (i_cmd.op)
            spq_pkg::OP_INSERT: n_count = r_count + CNT_W'(1);
            spq_pkg::OP_REMOVE: n_count = r_count - CNT_W'(1);
            default:            n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_rec <= i_record;
            r_in_pri <= i_priority;
        end
        if (i_cmd.exec) begin
            r_status <= i_cmd.status;
            if (i_cmd.op == spq_pkg::OP_REMOVE) begin
                r_head_rec   <= r_rec[0];
                r_head_pri   <= r_pri[0];
                r_head_valid <= 1'b1;
            end else begin
                r_head_rec   <= '0;
                r_head_pri   <= '0;
                r_head_valid <= 1'b0;
            end
        end
    end

    assign o_stat.full     = (r_count == CNT_W'(CAPACITY));
    assign o_stat.empty    = (r_count == '0);
    assign o_head_record   = r_head_rec;
    assign o_head_priority = r_head_pri;
    assign o_head_valid    = r_head_valid;
    assign o_status        = r_status;
    assign o_occupancy     = spq_pkg::OCC_W'(r_count);

endmodule

`default_nettype wire

### rtl/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_in_cmd,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output spq_pkg::t_dp_cmd         o_cmd,
    input  wire spq_pkg::t_dp_stat   i_stat
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_is_remove;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load   = w_accept;
        o_cmd.exec   = (r_state == S_EXEC) && w_slot_free;
        o_cmd.op     = spq_pkg::OP_IDLE;
        o_cmd.status = spq_pkg::ST_OK;
        if (r_is_remove) begin
            if (i_stat.empty) begin
                o_cmd.status = spq_pkg::ST_EMPTY;
            end else begin
                o_cmd.op = spq_pkg::OP_REMOVE;
            end
        end else begin
            if (i_stat.full) begin
                o_cmd.status = spq_pkg::ST_FULL;
            end else begin
                o_cmd.op = spq_pkg::OP_INSERT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_is_remove <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_is_remove <= (i_in_cmd == spq_pkg::CMD_REMOVE);
                        r_state     <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && o_cmd.op == spq_pkg::OP_INSERT) |-> !i_stat.full)
        else $error("insert issued on full queue");

    a_no_remove_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && o_cmd.op == spq_pkg::OP_REMOVE) |-> !i_stat.empty)
        else $error("remove issued on empty queue");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_out_valid)
        else $error("executed transaction without result");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC) && !o_in_ready)
        else $error("second transaction taken while busy");

    a_idle_op_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && o_cmd.op == spq_pkg::OP_IDLE) |-> (o_cmd.status != spq_pkg::ST_OK))
        else $error("no-op transaction reported ok");
`endif

endmodule

`default_nettype wire

### rtl/sorted_priority_queue.sv
`default_nettype none

// channel  dir  port    fields
// request  in   i_req   cmd, record, priority_req
// result   out  o_rsp   head_record, head_priority, head_valid, status, occupancy
//
// Each transaction is accepted, then executed as one compare-and-shift across all slots.
// The execute cycle waits while the previous result is still unclaimed.
// Reset (synchronous, active low) empties the queue; slot contents stay undefined.
// Request ready is low from acceptance until the execute cycle has completed.

module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    spq_pkg::t_dp_cmd  w_cmd;
    spq_pkg::t_dp_stat w_stat;
    logic              w_in_ready;
    logic              w_out_valid;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .i_in_cmd    (i_req.cmd),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_record        (i_req.record),
        .i_priority      (i_req.priority_req),
        .o_head_record   (o_rsp.head_record),
        .o_head_priority (o_rsp.head_priority),
        .o_head_valid    (o_rsp.head_valid),
        .o_status        (o_rsp.status),
        .o_occupancy     (o_rsp.occupancy)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

endmodule

`default_nettype wire
